// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define PPWL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PPWL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ppwl_pkg.sv
`default_nettype none
package ppwl_pkg;

  typedef enum logic [1:0] {
    CFG_BITS_MODE = 2'd0,
    CFG_CENTER    = 2'd1,
    CFG_WIDTH     = 2'd2,
    CFG_LINE      = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] MODE_8  = 2'd0;
  localparam logic [1:0] MODE_10 = 2'd1;
  localparam logic [1:0] MODE_12 = 2'd2;
  localparam logic [1:0] MODE_16 = 2'd3;

  localparam int CFG_DATA_W = 21;
  localparam int CENTER_W   = 21;
  localparam int WWIDTH_W   = 20;
  localparam int LINE_W     = 16;
  localparam int RECIP_W    = 32;
  localparam int N_W        = 22;
  localparam int PROD_W     = N_W + RECIP_W + 1;

  localparam logic [1:0]          BITS_MODE_RST = MODE_8;
  localparam logic [CENTER_W-1:0] CENTER_RST    = 21'd32768;
  localparam logic [LINE_W-1:0]   LINE_RST      = 16'd640;
  localparam logic [RECIP_W-1:0]  RECIP_RST     = 32'd32768;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [7:0] gray_out;
    logic       last_in_line;
  } out_t;

  typedef struct packed {
    logic        hit;
    logic        last;
    logic [15:0] scaled;
  } pix_t;

endpackage
`default_nettype wire

// File: rtl/ppwl_unpack.sv
`default_nettype none
module ppwl_unpack (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    bits_mode,
  input  wire logic [ppwl_pkg::LINE_W-1:0]   line_width,
  input  wire logic                          clear,
  input  wire logic                          take,
  input  wire ppwl_pkg::in_t                 beat,
  output ppwl_pkg::pix_t                     pix
);

  logic [23:0]                  bit_store;
  logic [4:0]                   bit_count;
  logic [ppwl_pkg::LINE_W-1:0]  pixel_count;

  logic [23:0]                  store_new;
  logic [23:0]                  store_keep;
  logic [4:0]                   count_add;
  logic [4:0]                   depth;
  logic [4:0]                   rest;
  logic [2:0]                   shift;
  logic [15:0]                  word;
  logic                         active;
  logic                         full;
  logic [ppwl_pkg::LINE_W-1:0]  count_inc;

  always_comb begin
    case (bits_mode)
      ppwl_pkg::MODE_8:  depth = 5'd8;
      ppwl_pkg::MODE_10: depth = 5'd10;
      ppwl_pkg::MODE_12: depth = 5'd12;
      default:           depth = 5'd16;
    endcase
  end

  assign store_new  = {bit_store[15:0], beat.source_byte};
  assign count_add  = bit_count + 5'd8;
  assign full       = count_add >= depth;
  assign rest       = count_add - depth;
  assign shift      = rest[2:0];
  assign word       = 16'(store_new >> shift);
  assign store_keep = store_new & ((24'd1 << shift) - 24'd1);
  assign active     = pixel_count < line_width;
  assign count_inc  = pixel_count + ppwl_pkg::LINE_W'(1);

  always_comb begin
    pix.hit  = active && full;
    pix.last = beat.line_end || (count_inc == line_width);
    case (bits_mode)
      ppwl_pkg::MODE_8:  pix.scaled = {word[7:0], 8'd0};
      ppwl_pkg::MODE_10: pix.scaled = {word[9:0], 6'd0};
      ppwl_pkg::MODE_12: pix.scaled = {word[11:0], 4'd0};
      default:           pix.scaled = {word[7:0], word[15:8]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store   <= '0;
      bit_count   <= '0;
      pixel_count <= '0;
    end else if (clear) begin
      bit_store <= '0;
      bit_count <= '0;
    end else if (take) begin
      if (beat.line_end) begin
        bit_store   <= '0;
        bit_count   <= '0;
        pixel_count <= '0;
      end else if (active) begin
        if (full) begin
          bit_store   <= store_keep;
          bit_count   <= rest;
          pixel_count <= count_inc;
        end else begin
          bit_store <= store_new;
          bit_count <= count_add;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppwl_recip.sv
`default_nettype none
module ppwl_recip (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ppwl_pkg::WWIDTH_W-1:0]  width,
  output logic                                busy,
  output logic [ppwl_pkg::RECIP_W-1:0]        recip
);

  logic [ppwl_pkg::WWIDTH_W-1:0] divisor;
  logic [ppwl_pkg::WWIDTH_W-1:0] rem;
  logic [ppwl_pkg::RECIP_W-1:0]  quot;
  logic [4:0]                    step;

  logic [ppwl_pkg::WWIDTH_W:0]   rem_shift;
  logic [ppwl_pkg::WWIDTH_W:0]   rem_sub;
  logic                          ge;
  logic [ppwl_pkg::RECIP_W-1:0]  quot_next;

  // dividend is 2^31: only its top bit is set
  assign rem_shift = {rem, step == 5'd31};
  assign ge        = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign quot_next = {quot[ppwl_pkg::RECIP_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      recip <= ppwl_pkg::RECIP_RST;
      step  <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      step    <= 5'd31;
      rem     <= '0;
      divisor <= (width == '0) ? ppwl_pkg::WWIDTH_W'(1) : width;
    end else if (busy) begin
      rem  <= ge ? rem_sub[ppwl_pkg::WWIDTH_W-1:0] : rem_shift[ppwl_pkg::WWIDTH_W-1:0];
      quot <= quot_next;
      step <= step - 5'd1;
      if (step == 5'd0) begin
        busy  <= 1'b0;
        recip <= quot_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/packed_pixel_window_level_map.sv
// Window/level map of a packed gray pixel stream.
// Input channel (in_valid/in_ready/in_data): one raw source byte per beat,
// with line_end on the last byte of each line. Bytes are unpacked into
// pixels of 8, 10, 12 (MSB first) or 16 bits (low byte first); each
// pixel gives one output beat (out_valid/out_ready/out_data) carrying its
// 8-bit windowed value and a last-in-line flag. Bytes that complete no
// pixel, and padding past line_width pixels, give no output beat.
// Throughput: one byte per cycle while in_ready is high. A pixel reaches
// out through three register stages (unpack/subtract, multiply,
// saturate). Configuration: cfg_we/cfg_index/cfg_data, written while
// idle. Writing the window width starts a bit-serial reciprocal;
// in_ready is low while it runs. Writing bits_mode drops pending bits.
// Reset: registers return to 8-bit mode, centre 0.5, width 1.0, 640
// pixels per line; pipeline empties and in_ready is high after reset.
// Stall: a held output is kept in place; the three stages fill behind it
// and, apart from the reciprocal, in_ready drops only when all are full.
`default_nettype none
module packed_pixel_window_level_map (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire ppwl_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output ppwl_pkg::out_t                         out_data,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [ppwl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [1:0]                           bits_mode;
  logic [ppwl_pkg::CENTER_W-1:0]        center;
  logic [ppwl_pkg::LINE_W-1:0]          line_width;

  logic                                 recip_busy;
  logic [ppwl_pkg::RECIP_W-1:0]         recip;
  ppwl_pkg::pix_t                       pix;

  logic                                 take;
  logic                                 mode_wr;
  logic                                 width_wr;
  logic                                 out_adv;
  logic                                 s2_adv;
  logic                                 s1_adv;

  logic                                 s1_valid;
  logic                                 s1_last;
  logic signed [ppwl_pkg::N_W-1:0]      s1_n;
  logic                                 s2_valid;
  logic                                 s2_last;
  logic signed [ppwl_pkg::PROD_W-1:0]   s2_prod;

  logic signed [ppwl_pkg::N_W-1:0]      n_next;
  logic signed [ppwl_pkg::PROD_W-1:0]   t_sum;
  logic [7:0]                           gray_next;

  assign mode_wr  = cfg_we && (cfg_index == ppwl_pkg::CFG_BITS_MODE);
  assign width_wr = cfg_we && (cfg_index == ppwl_pkg::CFG_WIDTH);

  assign out_adv  = !out_valid || out_ready;
  assign s2_adv   = !s2_valid || out_adv;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = !recip_busy && s1_adv;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_mode  <= ppwl_pkg::BITS_MODE_RST;
      center     <= ppwl_pkg::CENTER_RST;
      line_width <= ppwl_pkg::LINE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppwl_pkg::CFG_BITS_MODE: bits_mode  <= cfg_data[1:0];
        ppwl_pkg::CFG_CENTER:    center     <= cfg_data;
        ppwl_pkg::CFG_LINE:      line_width <= cfg_data[ppwl_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  ppwl_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (width_wr),
    .width (cfg_data[ppwl_pkg::WWIDTH_W-1:0]),
    .busy  (recip_busy),
    .recip (recip)
  );

  ppwl_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .bits_mode  (bits_mode),
    .line_width (line_width),
    .clear      (mode_wr),
    .take       (take),
    .beat       (in_data),
    .pix        (pix)
  );

  assign n_next = $signed({6'd0, pix.scaled}) - $signed({center[ppwl_pkg::CENTER_W-1], center});

  assign t_sum = s2_prod + $signed(ppwl_pkg::PROD_W'(1) << 30);

  always_comb begin
    if (t_sum[ppwl_pkg::PROD_W-1]) begin
      gray_next = 8'd0;
    end else if (|t_sum[ppwl_pkg::PROD_W-2:31]) begin
      gray_next = 8'd255;
    end else begin
      gray_next = t_sum[30:23];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= take && pix.hit;
        s1_n     <= n_next;
        s1_last  <= pix.last;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
        s2_prod  <= s1_n * $signed({1'b0, recip});
        s2_last  <= s1_last;
      end
      if (out_adv) begin
        out_valid             <= s2_valid;
        out_data.gray_out     <= gray_next;
        out_data.last_in_line <= s2_last;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppwl_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ppwl_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire ppwl_pkg::in_t                     in_data,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire ppwl_pkg::out_t                    out_data,
  input wire logic                              cfg_we,
  input wire logic [1:0]                        cfg_index,
  input wire logic [ppwl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_data, cfg_data};

  `PPWL_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "output beat changed while stalled")
  `PPWL_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")
  `PPWL_ASSERT(a_recip_block, clk, rst, cfg_we && (cfg_index == ppwl_pkg::CFG_WIDTH) |=> !in_ready, "input taken during reciprocal")

endmodule

bind packed_pixel_window_level_map ppwl_checker u_checker (.*);
`default_nettype wire

// File: tb/sv/ppwl_window_checker.sv
`timescale 1ns / 1ps
module ppwl_window_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  ppwl_pkg::in_t                     in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  ppwl_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [ppwl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                pixels_checked
);

  logic [1:0]         depth_mode;
  logic signed [20:0] centre;
  logic [19:0]        win_width;
  logic [31:0]        recip;
  logic [15:0]        line_len;
  logic [23:0]        bit_store;
  logic [4:0]         bit_cnt;
  logic [15:0]        pix_cnt;

  ppwl_pkg::out_t expected_pixels[$];
  ppwl_pkg::out_t predicted;
  ppwl_pkg::out_t oldest;
  bit             produced;

  function automatic logic [31:0] width_recip(logic [19:0] w);
    logic [31:0] w_eff;
    w_eff = (w == 20'd0) ? 32'd1 : {12'd0, w};
    return 32'h8000_0000 / w_eff;
  endfunction

  function automatic logic [7:0] window_map(logic [15:0] s);
    longint n;
    longint t;
    n = longint'(s) - longint'(centre);
    t = n * longint'(recip) + (longint'(128) << 23);
    if (t < 0) return 8'd0;
    if ((t >>> 23) > 255) return 8'd255;
    return t[30:23];
  endfunction

  task automatic unpack_byte(input ppwl_pkg::in_t beat, output bit got_pixel,
                             output ppwl_pkg::out_t px);
    int unsigned b;
    int unsigned rest;
    int unsigned x;
    logic [15:0] w16;
    got_pixel = 1'b0;
    px = '0;
    case (depth_mode)
      ppwl_pkg::MODE_8:  b = 8;
      ppwl_pkg::MODE_10: b = 10;
      ppwl_pkg::MODE_12: b = 12;
      default:           b = 16;
    endcase
    if (pix_cnt < line_len) begin
      bit_store = {bit_store[15:0], beat.source_byte};
      bit_cnt = bit_cnt + 5'd8;
      if (bit_cnt >= b) begin
        rest = bit_cnt - b;
        if (b == 16) begin
          w16 = 16'(bit_store >> rest);
          x = {w16[7:0], w16[15:8]};
        end else begin
          x = (bit_store >> rest) & ((1 << b) - 1);
        end
        bit_cnt = 5'(rest);
        bit_store = bit_store & ((24'd1 << rest) - 24'd1);
        pix_cnt = pix_cnt + 16'd1;
        px.gray_out = window_map(16'(x << (16 - b)));
        px.last_in_line = beat.line_end || (pix_cnt == line_len);
        got_pixel = 1'b1;
      end
    end
    if (beat.line_end) begin
      bit_store = '0;
      bit_cnt = '0;
      pix_cnt = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input ppwl_pkg::out_t want,
                               input ppwl_pkg::out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected gray %0d last %0b, got gray %0d last %0b", $realtime, what,
               want.gray_out, want.last_in_line, got.gray_out, got.last_in_line);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      depth_mode = ppwl_pkg::BITS_MODE_RST;
      centre = ppwl_pkg::CENTER_RST;
      win_width = 20'd65536;
      recip = ppwl_pkg::RECIP_RST;
      line_len = ppwl_pkg::LINE_RST;
      bit_store = '0;
      bit_cnt = '0;
      pix_cnt = '0;
      expected_pixels.delete();
      fail_count = 0;
      pixels_checked = 0;
    end else begin
      if (cfg_we) begin
        case (ppwl_pkg::cfg_idx_t'(cfg_index))
          ppwl_pkg::CFG_BITS_MODE: begin
            depth_mode = cfg_data[1:0];
            bit_store = '0;
            bit_cnt = '0;
          end
          ppwl_pkg::CFG_CENTER: centre = cfg_data[20:0];
          ppwl_pkg::CFG_WIDTH: begin
            win_width = cfg_data[19:0];
            recip = width_recip(win_width);
          end
          default: line_len = cfg_data[15:0];
        endcase
      end
      if (in_valid && in_ready) begin
        unpack_byte(in_data, produced, predicted);
        if (produced) expected_pixels.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch("beat with nothing expected", '0, out_data);
        end else begin
          oldest = expected_pixels.pop_front();
          pixels_checked++;
          if (oldest.gray_out !== out_data.gray_out ||
              oldest.last_in_line !== out_data.last_in_line)
            flag_mismatch("pixel mismatch", oldest, out_data);
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// File: tb/sv/tb_packed_pixel_window_level_map.sv
`timescale 1ns / 1ps
module tb_packed_pixel_window_level_map;

  localparam int RANDOM_BYTES = 950;
  localparam int LONG_HOLD    = 200;
  localparam int IDLE_GUARD   = 8;
  localparam int DRAIN_CYCLES = 16;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  ppwl_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_ready;
  ppwl_pkg::out_t                  out_data;
  logic                            cfg_we;
  logic [1:0]                      cfg_index;
  logic [ppwl_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int pixels_checked;
  int bytes_sent = 0;
  int settings_used = 0;
  bit no_idle = 1'b0;
  bit long_hold = 1'b0;

  always #5 clk = ~clk;

  packed_pixel_window_level_map uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppwl_window_checker pixel_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // output side: random back-pressure, one long hold on request
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic eol);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{source_byte: value, line_end: eol};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_line(input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++)
      send_byte(8'($urandom_range(0, 255)), i == nbytes - 1);
  endtask

  // block idle first; width goes last as it starts the reciprocal
  task automatic write_regs(input logic [1:0] mode, input int centre, input int unsigned wwidth,
                            input int unsigned line);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ppwl_pkg::CFG_BITS_MODE;
    cfg_data <= {19'd0, mode};
    @(posedge clk);
    cfg_index <= ppwl_pkg::CFG_CENTER;
    cfg_data <= centre[20:0];
    @(posedge clk);
    cfg_index <= ppwl_pkg::CFG_LINE;
    cfg_data <= {5'd0, line[15:0]};
    @(posedge clk);
    cfg_index <= ppwl_pkg::CFG_WIDTH;
    cfg_data <= {1'b0, wwidth[19:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int unsigned line_bytes(logic [1:0] mode, int unsigned pixels);
    int unsigned b;
    case (mode)
      ppwl_pkg::MODE_8:  b = 8;
      ppwl_pkg::MODE_10: b = 10;
      ppwl_pkg::MODE_12: b = 12;
      default:           b = 16;
    endcase
    return (pixels * b + 7) / 8;
  endfunction

  initial begin
    int          phase;
    int          limit;
    int          phase_end;
    int          centre_v;
    int unsigned width_v;
    int unsigned line_v;
    int unsigned need;
    int unsigned nbytes;
    logic [1:0]  mode_v;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = ppwl_pkg::CFG_BITS_MODE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 8-bit depth, centre 0.5, width 1.0
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);

    // 10-bit, widest window, two pixels then a padding byte
    write_regs(ppwl_pkg::MODE_10, 0, 20'hFFFFF, 2);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b1);

    // 12-bit, top centre, zero width; a short line then a full one with padding
    write_regs(ppwl_pkg::MODE_12, 1048575, 0, 3);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b1);

    // zero line width: all padding
    write_regs(ppwl_pkg::MODE_16, -1048576, 1, 0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);

    // 16-bit low byte first, partial pixel dropped at line end
    write_regs(ppwl_pkg::MODE_16, 32768, 65536, 65535);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);

    // depth change drops the pending half pixel
    send_byte(8'hAB, 1'b0);
    write_regs(ppwl_pkg::MODE_8, 32768, 65536, 640);
    send_byte(8'h5A, 1'b1);

    limit = bytes_sent + RANDOM_BYTES;
    phase = 0;
    while (bytes_sent < limit) begin
      mode_v = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       centre_v = -1048576;
        1:       centre_v = 1048575;
        default: centre_v = int'($urandom_range(0, 98304)) - 16384;
      endcase
      case ($urandom_range(0, 7))
        0:       width_v = 1;
        1:       width_v = 20'hFFFFF;
        2:       width_v = $urandom_range(1, 20'hFFFFF);
        default: width_v = $urandom_range(8192, 131072);
      endcase
      case ($urandom_range(0, 9))
        0:       line_v = 0;
        1:       line_v = 65535;
        2:       line_v = $urandom_range(13, 65535);
        default: line_v = $urandom_range(1, 12);
      endcase
      if (phase == 4) begin
        mode_v = ppwl_pkg::MODE_8;
        line_v = 16;
      end
      write_regs(mode_v, centre_v, width_v, line_v);
      no_idle = (phase % 5 == 3) || (phase == 4);
      if (phase == 4) long_hold = 1'b1;
      phase_end = bytes_sent + $urandom_range(40, 90);
      while (bytes_sent < phase_end) begin
        need = line_bytes(mode_v, line_v);
        case ($urandom_range(0, 9))
          7, 8:    nbytes = $urandom_range(1, (need > 0) ? need : 1);
          9:       nbytes = $urandom_range(1, 24);
          default: nbytes = need + $urandom_range(0, 3);
        endcase
        if (need == 0 || need > 40) nbytes = $urandom_range(1, 40);
        send_line(nbytes);
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d pixels from %0d source bytes over %0d register settings.",
             pixels_checked, bytes_sent, settings_used);
    $display("Covered all four depths, window extremes, zero width, padding, short lines, "
             , "depth change mid-line and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
